// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

  localparam int REQ_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic                  is_empty;
    logic [COUNT_W-1:0]    entry_count;
    logic [POS_W-1:0]      found_position;
    logic [DATA_W-1:0]     popped_value;
  } result_t;

endpackage

// ----- hw/rtl/bounded_deque_with_search_core.sv -----
// Request flow: the request is registered in S_IDLE; pushes and unknown request
// types load the result from S_EXEC; pops read the store in S_EXEC and load the
// result from S_POP; a search reads the front entry in S_EXEC, then compares one
// stored entry per cycle in S_SEARCH through the store's single read port. One
// request at a time; the next one is taken the cycle after the result is loaded.
// Reset (rst, synchronous): sequence empty, front index zero, no result pending.
module bounded_deque_with_search_core #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_value
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] popped_value, [35:32] found_position,
                                 // [40:36] entry_count, [41] is_empty, rest zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0]   CAP_SUM  = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam int PAD_W = 48 - $bits(bdq_pkg::result_t);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP, S_SEARCH} state_t;

  state_t                       state, state_next;
  logic [IDX_W-1:0]             front, front_next;
  logic [CNT_W-1:0]             count, count_next;
  logic [IDX_W-1:0]             idx, idx_next;
  logic [bdq_pkg::REQ_W-1:0]    req_type;
  logic [bdq_pkg::DATA_W-1:0]   req_value;
  logic [VALUE_WIDTH-1:0]       req_val_w;

  logic [VALUE_WIDTH-1:0]       mem [CAPACITY];
  logic [VALUE_WIDTH-1:0]       rd_data;
  logic                         mem_we, mem_re;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;

  logic                         out_free, emit;
  logic [bdq_pkg::STATUS_W-1:0] res_status;
  logic [bdq_pkg::DATA_W-1:0]   res_popped;
  logic [IDX_W-1:0]             res_pos;
  bdq_pkg::result_t             res;
  logic                         full, empty;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= CAP_SUM) begin
      sum = sum - CAP_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign req_val_w = VALUE_WIDTH'($unsigned(req_value));
  assign full      = (count == CAP_CNT);
  assign empty     = (count == '0);

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    mem_we     = 1'b0;
    mem_waddr  = front;
    mem_re     = 1'b0;
    mem_raddr  = front;
    emit       = 1'b0;
    res_status = bdq_pkg::ST_OK;
    res_popped = '0;
    res_pos    = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_type)
          bdq_pkg::REQ_PUSH_FRONT, bdq_pkg::REQ_PUSH_BACK: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (full) begin
                res_status = bdq_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                if (req_type == bdq_pkg::REQ_PUSH_FRONT) begin
                  front_next = (front == '0) ? LAST_IDX : front - 1'b1;
                  mem_waddr  = front_next;
                end else begin
                  mem_waddr = ring_add(front, IDX_W'(count));
                end
              end
            end
          end
          bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
            if (empty) begin
              if (out_free) begin
                emit       = 1'b1;
                res_status = bdq_pkg::ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              mem_re     = 1'b1;
              count_next = count - 1'b1;
              state_next = S_POP;
              if (req_type == bdq_pkg::REQ_POP_FRONT) begin
                mem_raddr  = front;
                front_next = (front == LAST_IDX) ? '0 : front + 1'b1;
              end else begin
                mem_raddr = ring_add(front, IDX_W'(count - 1'b1));
              end
            end
          end
          bdq_pkg::REQ_SEARCH: begin
            if (empty) begin
              if (out_free) begin
                emit       = 1'b1;
                res_status = bdq_pkg::ST_NOT_FOUND;
                state_next = S_IDLE;
              end
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = front;
              idx_next   = '0;
              state_next = S_SEARCH;
            end
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (out_free) begin
          emit       = 1'b1;
          res_popped = bdq_pkg::DATA_W'(rd_data);
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (rd_data == req_val_w) begin
          if (out_free) begin
            emit       = 1'b1;
            res_pos    = idx;
            state_next = S_IDLE;
          end
        end else if (idx == IDX_W'(count - 1'b1)) begin
          if (out_free) begin
            emit       = 1'b1;
            res_status = bdq_pkg::ST_NOT_FOUND;
            state_next = S_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          idx_next  = idx + 1'b1;
          mem_raddr = ring_add(front, idx_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.popped_value   = res_popped;
    res.found_position = bdq_pkg::POS_W'(res_pos);
    res.entry_count    = bdq_pkg::COUNT_W'(count_next);
    res.is_empty       = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_val_w;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
      if (state == S_IDLE && s_tvalid) begin
        req_type  <= s_tuser;
        req_value <= s_tdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {PAD_W'(0), res};
        m_tuser  <= res_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front <= LAST_IDX)
    else $error("front index outside store");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && emit && !full &&
     (req_type == bdq_pkg::REQ_PUSH_FRONT || req_type == bdq_pkg::REQ_PUSH_BACK))
    |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow the sequence");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending transaction");

endmodule
